### rtl/mtrd_pkg.sv
package mtrd_pkg;

   // Default number of entries in the record queue between front and back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Configuration space: a single register at byte address zero.
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRACE_FORMAT = 1'b0;

   // Record type codes taken from header bits 6:4.
   localparam logic [2:0] TYPE_CODE = 3'd3;
   localparam logic [2:0] TYPE_COMP = 3'd4;

   // Trace format that allows compressed code records.
   localparam logic [1:0] FORMAT_COMP = 2'd2;

   localparam logic [1:0] CMD_READ = 2'd0;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_VIRT0,
      PH_VIRT1,
      PH_VIRT2,
      PH_VIRT3,
      PH_PHYS0,
      PH_PHYS1,
      PH_PHYS2
   } phase_type;

   typedef enum logic [1:0] {
      REC_END,
      REC_TRUNC,
      REC_FULL,
      REC_COMP
   } rec_kind_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_END,
      ST_FORMAT,
      ST_CORRUPT,
      ST_TRUNC,
      ST_UNKNOWN
   } status_type;

   // One parsed record as it travels from the front end to the back end.
   typedef struct packed {
      rec_kind_type kind;
      logic [7:0]   header;
      logic [31:0]  virt;
      logic [35:0]  phys;
   } rec_type;

   typedef struct packed {
      logic    valid;
      rec_type rec;
   } queue_push_type;

endpackage

### rtl/mtrd_req_if.sv
interface mtrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_trace;

   modport source (output valid, output data_byte, output end_of_trace, input ready);
   modport sink (input valid, input data_byte, input end_of_trace, output ready);
endinterface

### rtl/mtrd_rsp_if.sv
interface mtrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] virt_addr;
   logic [35:0] phys_addr;
   logic [4:0]  access_size;
   logic [1:0]  command;
   logic        instr_fetch;
   logic [2:0]  status;

   modport source (output valid, output virt_addr, output phys_addr, output access_size,
                   output command, output instr_fetch, output status, input ready);
   modport sink (input valid, input virt_addr, input phys_addr, input access_size,
                 input command, input instr_fetch, input status, output ready);
endinterface

### rtl/memory_trace_record_decoder.sv
// Channel   Dir  Handshake     Payload
// req_chan  in   valid/ready   data_byte[7:0], end_of_trace
// rsp_chan  out  valid/ready   virt_addr, phys_addr, access_size, command, instr_fetch, status
// APB       in   psel/penable  paddr, pwdata, prdata (trace_format at byte address 0)
//
// One trace byte is taken per clock while the record queue has room.
// A result is offered on rsp_chan after the last byte of its record has been written into the
// queue and the back end has resolved the record at the queue head and loaded the output register.
// Reset is synchronous and active high; it clears control state and needs no clearing pass.
// A stalled result holds in the output register while the queue keeps taking bytes as long as it has room.
module memory_trace_record_decoder
   import mtrd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   mtrd_req_if.sink              req_chan,
   mtrd_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // Trace format register. Only the value that allows compressed code
   // records matters to the decoder; all other values behave alike.
   logic [1:0]     trace_format_ff, trace_format_in;
   logic           csr_write;

   queue_push_type push;
   rec_type        head;
   logic           q_empty;
   logic           q_full;
   logic           pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      trace_format_in = trace_format_ff;
      if (csr_write && (paddr == CSR_TRACE_FORMAT)) begin
         trace_format_in = pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_format_ff <= '0;
      end else begin
         trace_format_ff <= trace_format_in;
      end
   end

   assign prdata = (paddr == CSR_TRACE_FORMAT) ? {30'd0, trace_format_ff} : '0;

   // The front end walks the byte stream and hands complete records,
   // compressed headers and end-of-trace markers to the queue.
   mtrd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   mtrd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .empty (q_empty),
      .full  (q_full)
   );

   // The back end owns the running code addresses, so records are resolved
   // strictly in stream order, one per cycle when the output can take it.
   mtrd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .empty        (q_empty),
      .trace_format (trace_format_ff),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

endmodule

### rtl/mtrd_front.sv
module mtrd_front
   import mtrd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   mtrd_req_if.sink       req_chan,
   input  logic           q_full,
   output queue_push_type push
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  header_ff, header_in;
   logic [31:0] virt_ff, virt_in;
   logic [35:0] phys_ff, phys_in;
   logic        accept;
   logic [7:0]  b;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign b = req_chan.data_byte;

   // Next parse phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_chan.end_of_trace) begin
            phase_in = PH_HEADER;
         end else begin
            unique case (phase_ff)
               PH_HEADER: phase_in = (b[6:4] == TYPE_COMP) ? PH_HEADER : PH_VIRT0;
               PH_VIRT0:  phase_in = PH_VIRT1;
               PH_VIRT1:  phase_in = PH_VIRT2;
               PH_VIRT2:  phase_in = PH_VIRT3;
               PH_VIRT3:  phase_in = header_ff[7] ? PH_PHYS0 : PH_HEADER;
               PH_PHYS0:  phase_in = PH_PHYS1;
               PH_PHYS1:  phase_in = PH_PHYS2;
               PH_PHYS2:  phase_in = PH_HEADER;
               default:   phase_in = PH_HEADER;
            endcase
         end
      end
   end

   // Field assembly: the header byte is latched and each address byte lands in its slot of the address accumulators.
   always_comb begin
      header_in = header_ff;
      virt_in   = virt_ff;
      phys_in   = phys_ff;
      if (accept && !req_chan.end_of_trace) begin
         unique case (phase_ff)
            PH_HEADER: begin
               header_in = b;
               virt_in   = '0;
               phys_in   = '0;
            end
            PH_VIRT0: virt_in[7:0]   = b;
            PH_VIRT1: virt_in[15:8]  = b;
            PH_VIRT2: virt_in[23:16] = b;
            PH_VIRT3: begin
               virt_in[31:24] = b;
               phys_in = {24'd0, virt_ff[11:0]};
            end
            PH_PHYS0: begin
               phys_in[15:12] = b[7:4];
               phys_in[35:32] = b[3:0];
            end
            PH_PHYS1: phys_in[23:16] = b;
            PH_PHYS2: phys_in[31:24] = b;
            default: ;
         endcase
      end
   end

   // Record hand-off to the queue.
   always_comb begin
      push.valid      = 1'b0;
      push.rec.kind   = REC_FULL;
      push.rec.header = (phase_ff == PH_HEADER) ? b : header_ff;
      push.rec.virt   = virt_in;
      push.rec.phys   = phys_in;
      if (accept) begin
         if (req_chan.end_of_trace) begin
            push.valid    = 1'b1;
            push.rec.kind = (phase_ff == PH_HEADER) ? REC_END : REC_TRUNC;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  push.valid    = (b[6:4] == TYPE_COMP);
                  push.rec.kind = REC_COMP;
               end
               PH_VIRT3: push.valid = !header_ff[7];
               PH_PHYS2: push.valid = 1'b1;
               default:  push.valid = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      header_ff <= header_in;
      virt_ff   <= virt_in;
      phys_ff   <= phys_in;
   end

endmodule

### rtl/mtrd_queue.sv
module mtrd_queue
   import mtrd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  queue_push_type push,
   input  logic           pop,
   output rec_type        head,
   output logic           empty,
   output logic           full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rec_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.rec;
      end
   end

endmodule

### rtl/mtrd_back.sv
module mtrd_back
   import mtrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  rec_type     head,
   input  logic        empty,
   input  logic [1:0]  trace_format,
   output logic        pop,
   mtrd_rsp_if.source  rsp_chan
);

   // True when an access starting at this page offset reaches or runs past the page end.
   function automatic logic crosses(logic [11:0] offset, logic [4:0] size);
      logic [12:0] sum;
      sum = {1'b0, offset} + {8'd0, size};
      return sum[12];
   endfunction

   logic [31:0] code_virt_next_ff, code_virt_next_in;
   logic        code_virt_ok_ff, code_virt_ok_in;
   logic [35:0] code_phys_next_ff, code_phys_next_in;
   logic        code_phys_ok_ff, code_phys_ok_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_virt_ff;
   logic [35:0] rsp_phys_ff;
   logic [4:0]  rsp_size_ff;
   logic [1:0]  rsp_command_ff;
   logic        rsp_inst_ff;
   status_type  rsp_status_ff;

   logic        res_valid;
   logic [31:0] res_virt;
   logic [35:0] res_phys;
   logic [4:0]  res_size;
   logic [1:0]  res_command;
   logic        res_inst;
   status_type  res_status;

   logic [2:0]  rtype;
   logic        has_phys;
   logic [4:0]  size;
   logic        out_free;

   assign rtype    = head.header[6:4];
   assign has_phys = head.header[7];
   assign size     = {1'b0, head.header[3:0]} + 5'd1;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = !empty && (!res_valid || out_free);

   always_comb begin
      res_valid         = 1'b0;
      res_virt          = '0;
      res_phys          = '0;
      res_size          = '0;
      res_command       = CMD_READ;
      res_inst          = 1'b0;
      res_status        = ST_OK;
      code_virt_next_in = code_virt_next_ff;
      code_virt_ok_in   = code_virt_ok_ff;
      code_phys_next_in = code_phys_next_ff;
      code_phys_ok_in   = code_phys_ok_ff;
      unique case (head.kind)
         REC_END: begin
            res_valid  = 1'b1;
            res_status = ST_END;
         end
         REC_TRUNC: begin
            res_valid  = 1'b1;
            res_status = ST_TRUNC;
         end
         REC_FULL: begin
            if (rtype > TYPE_CODE) begin
               res_valid  = 1'b1;
               res_status = ST_UNKNOWN;
            end else begin
               if (rtype == TYPE_CODE) begin
                  code_virt_next_in = head.virt + 32'(size);
                  code_virt_ok_in   = 1'b1;
                  if (has_phys && !crosses(head.phys[11:0], size)) begin
                     code_phys_next_in = head.phys + 36'(size);
                     code_phys_ok_in   = 1'b1;
                  end else begin
                     code_phys_ok_in = 1'b0;
                  end
               end
               if (has_phys) begin
                  res_valid   = 1'b1;
                  res_virt    = head.virt;
                  res_phys    = head.phys;
                  res_size    = size;
                  res_command = (rtype == TYPE_CODE) ? CMD_READ : rtype[1:0];
                  res_inst    = (rtype == TYPE_CODE);
               end
            end
         end
         REC_COMP: begin
            if (trace_format != FORMAT_COMP) begin
               res_valid  = 1'b1;
               res_status = ST_FORMAT;
            end else if (!code_virt_ok_ff || (has_phys && !code_phys_ok_ff)) begin
               res_valid  = 1'b1;
               res_status = ST_CORRUPT;
            end else begin
               code_virt_next_in = code_virt_next_ff + 32'(size);
               if (!has_phys) begin
                  code_phys_ok_in = 1'b0;
               end else begin
                  res_valid = 1'b1;
                  res_virt  = code_virt_next_ff;
                  res_phys  = code_phys_next_ff;
                  res_size  = size;
                  if (crosses(code_phys_next_ff[11:0], size)) begin
                     code_phys_ok_in = 1'b0;
                  end else begin
                     code_phys_next_in = code_phys_next_ff + 36'(size);
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_virt_ok_ff <= 1'b0;
         code_phys_ok_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (pop) begin
            code_virt_ok_ff <= code_virt_ok_in;
            code_phys_ok_ff <= code_phys_ok_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         code_virt_next_ff <= code_virt_next_in;
         code_phys_next_ff <= code_phys_next_in;
      end
      if (pop && res_valid) begin
         rsp_virt_ff    <= res_virt;
         rsp_phys_ff    <= res_phys;
         rsp_size_ff    <= res_size;
         rsp_command_ff <= res_command;
         rsp_inst_ff    <= res_inst;
         rsp_status_ff  <= res_status;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.virt_addr   = rsp_virt_ff;
   assign rsp_chan.phys_addr   = rsp_phys_ff;
   assign rsp_chan.access_size = rsp_size_ff;
   assign rsp_chan.command     = rsp_command_ff;
   assign rsp_chan.instr_fetch = rsp_inst_ff;
   assign rsp_chan.status      = rsp_status_ff;

endmodule
